>>> sv/cmfb_pkg.sv
package cmfb_pkg;

	localparam int unsigned SLOTS_PER_BUS   = 4;
	localparam int unsigned SLOT_COUNT      = 8;
	localparam int unsigned SLOT_W          = 3;
	localparam int unsigned BUS0_FIRST_SLOT = 4;
	localparam int unsigned ID_W            = 11;
	localparam int unsigned ANGLE_W         = 16;
	localparam int unsigned TURNS_W         = 32;
	localparam int unsigned CFG_ADDR_W      = 2;
	localparam int unsigned CFG_DATA_W      = 16;

	localparam logic [ID_W-1:0]       BUS0_BASE_RST = 11'd513;
	localparam logic [ID_W-1:0]       BUS1_BASE_RST = 11'd513;
	localparam logic [SLOT_COUNT-1:0] MASK_RST      = 8'd31;
	localparam logic [ANGLE_W-1:0]    THRESH_RST    = 16'd5000;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_BUS0_BASE = 2'd0,
		REG_BUS1_BASE = 2'd1,
		REG_TURN_MASK = 2'd2,
		REG_WRAP_THR  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
	} slot_sel_t;

	typedef struct packed {
		logic upd;
		logic clr;
	} track_ctl_t;

endpackage

>>> sv/can_motor_feedback_turn_counter.sv
// Motor feedback turn counter. Each request on the s_ side is one received
// CAN feedback frame; a frame whose ID falls in a bus's slot range gives one
// request on the m_ side with the slot's new angle, speed, current,
// temperature and updated multi-turn count, other frames give none (a clear
// still applies). One frame is taken every cycle unless a stalled output holds
// the input register; a taken frame goes to the input register, then the slot
// lookup, angle step compare and count update fill the output register. A
// stalled output holds the frame in the input register until the result moves.
module can_motor_feedback_turn_counter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// std_id[10:0], byte0..byte6 [66:11], clear_turns[67], zero fill
	input  logic [71:0]                         s_tdata,
	// bus
	input  logic [0:0]                          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// angle[15:0], speed[31:16], current[47:32], temperature[55:48], turns[87:56]
	output logic [87:0]                         m_tdata,
	// slot
	output logic [cmfb_pkg::SLOT_W-1:0]         m_tuser,
	input  logic                                cfg_we,
	input  logic [cmfb_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [cmfb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	logic [cmfb_pkg::ID_W-1:0]       bus0_base_q;
	logic [cmfb_pkg::ID_W-1:0]       bus1_base_q;
	logic [cmfb_pkg::SLOT_COUNT-1:0] mask_q;
	logic [cmfb_pkg::ANGLE_W-1:0]    thresh_q;

	logic        valid_s1;
	logic [71:0] data_s1;
	logic        bus_s1;

	logic                          out_valid_q;
	logic [87:0]                   out_data_q;
	logic [cmfb_pkg::SLOT_W-1:0]   out_slot_q;

	logic                                 adv;
	cmfb_pkg::slot_sel_t                  sel;
	cmfb_pkg::track_ctl_t                 ctl;
	logic signed [cmfb_pkg::TURNS_W-1:0]  turns_new;
	logic [cmfb_pkg::ANGLE_W-1:0]         angle_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus0_base_q <= cmfb_pkg::BUS0_BASE_RST;
			bus1_base_q <= cmfb_pkg::BUS1_BASE_RST;
			mask_q      <= cmfb_pkg::MASK_RST;
			thresh_q    <= cmfb_pkg::THRESH_RST;
		end else if (cfg_we) begin
			unique case (cmfb_pkg::cfg_reg_t'(cfg_addr))
				cmfb_pkg::REG_BUS0_BASE: bus0_base_q <= cfg_wdata[cmfb_pkg::ID_W-1:0];
				cmfb_pkg::REG_BUS1_BASE: bus1_base_q <= cfg_wdata[cmfb_pkg::ID_W-1:0];
				cmfb_pkg::REG_TURN_MASK: mask_q <= cfg_wdata[cmfb_pkg::SLOT_COUNT-1:0];
				cmfb_pkg::REG_WRAP_THR:  thresh_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			bus_s1  <= s_tuser[0];
		end
	end

	cmfb_slot_map u_map (
		.bus       (bus_s1),
		.std_id    (data_s1[10:0]),
		.bus0_base (bus0_base_q),
		.bus1_base (bus1_base_q),
		.sel       (sel)
	);

	assign angle_s1 = {data_s1[18:11], data_s1[26:19]};
	assign ctl.upd  = adv && valid_s1 && sel.hit;
	assign ctl.clr  = adv && valid_s1 && data_s1[67];

	cmfb_turn_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.slot      (sel.slot),
		.new_angle (angle_s1),
		.mask      (mask_q),
		.thresh    (thresh_q),
		.turns_new (turns_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1 && sel.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.upd) begin
			out_slot_q <= sel.slot;
			out_data_q <= {turns_new, data_s1[66:59], data_s1[50:43], data_s1[58:51],
				data_s1[34:27], data_s1[42:35], angle_s1};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_slot_q;

endmodule

>>> sv/cmfb_slot_map.sv
module cmfb_slot_map (
	input  logic                      bus,
	input  logic [cmfb_pkg::ID_W-1:0] std_id,
	input  logic [cmfb_pkg::ID_W-1:0] bus0_base,
	input  logic [cmfb_pkg::ID_W-1:0] bus1_base,
	output cmfb_pkg::slot_sel_t       sel
);

	logic [cmfb_pkg::ID_W-1:0] base;
	logic [cmfb_pkg::ID_W:0]   diff;
	logic [cmfb_pkg::ID_W-1:0] offset;
	logic [cmfb_pkg::ID_W-1:0] bus0_slot;

	always_comb begin
		base      = bus ? bus1_base : bus0_base;
		diff      = {1'b0, std_id} - {1'b0, base};
		offset    = diff[cmfb_pkg::ID_W-1:0];
		bus0_slot = offset + cmfb_pkg::ID_W'(cmfb_pkg::BUS0_FIRST_SLOT);
		sel.hit   = !diff[cmfb_pkg::ID_W]
			&& (offset < cmfb_pkg::ID_W'(cmfb_pkg::SLOTS_PER_BUS));
		sel.slot  = bus ? offset[cmfb_pkg::SLOT_W-1:0] : bus0_slot[cmfb_pkg::SLOT_W-1:0];
	end

endmodule

>>> sv/cmfb_turn_track.sv
module cmfb_turn_track (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cmfb_pkg::track_ctl_t              ctl,
	input  logic [cmfb_pkg::SLOT_W-1:0]       slot,
	input  logic [cmfb_pkg::ANGLE_W-1:0]      new_angle,
	input  logic [cmfb_pkg::SLOT_COUNT-1:0]   mask,
	input  logic [cmfb_pkg::ANGLE_W-1:0]      thresh,
	output logic signed [cmfb_pkg::TURNS_W-1:0] turns_new
);

	logic [cmfb_pkg::ANGLE_W-1:0] angle_q [cmfb_pkg::SLOT_COUNT];
	logic [cmfb_pkg::TURNS_W-1:0] turns_q [cmfb_pkg::SLOT_COUNT];

	logic [cmfb_pkg::ANGLE_W:0]          diff;
	logic signed [cmfb_pkg::ANGLE_W+1:0] step;
	logic signed [cmfb_pkg::ANGLE_W+1:0] thr_s;
	logic [cmfb_pkg::TURNS_W-1:0]        turns_old;
	logic                                dec;
	logic                                inc;

	always_comb begin
		diff      = {1'b0, new_angle} - {1'b0, angle_q[slot]};
		step      = signed'({diff[cmfb_pkg::ANGLE_W], diff});
		thr_s     = signed'({2'b00, thresh});
		turns_old = ctl.clr ? '0 : turns_q[slot];
		dec       = mask[slot] && (step > thr_s);
		inc       = mask[slot] && (step < -thr_s);
		turns_new = signed'(turns_old + (inc ? cmfb_pkg::TURNS_W'(1) : '0)
			- (dec ? cmfb_pkg::TURNS_W'(1) : '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < cmfb_pkg::SLOT_COUNT; k++) begin
				angle_q[k] <= '0;
				turns_q[k] <= '0;
			end
		end else begin
			for (int k = 0; k < cmfb_pkg::SLOT_COUNT; k++) begin
				if (ctl.upd && (slot == cmfb_pkg::SLOT_W'(k))) begin
					angle_q[k] <= new_angle;
					turns_q[k] <= turns_new;
				end else if (ctl.clr) begin
					turns_q[k] <= '0;
				end
			end
		end
	end

endmodule

>>> bench/turn_count_checker.sv
module turn_count_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	// std_id[10:0], byte0..byte6 [66:11], clear_turns[67], zero fill
	input  logic [71:0]                     s_tdata,
	// bus
	input  logic [0:0]                      s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	// angle[15:0], speed[31:16], current[47:32], temperature[55:48], turns[87:56]
	input  logic [87:0]                     m_tdata,
	// slot
	input  logic [cmfb_pkg::SLOT_W-1:0]     m_tuser,
	input  logic                            cfg_we,
	input  logic [cmfb_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [cmfb_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                              errors,
	output int                              checked,
	output int                              pending
);

	typedef struct {
		logic [cmfb_pkg::SLOT_W-1:0]         slot;
		logic [cmfb_pkg::ANGLE_W-1:0]        angle;
		logic signed [15:0]                  speed;
		logic [15:0]                         current;
		logic [7:0]                          temperature;
		logic signed [cmfb_pkg::TURNS_W-1:0] turns;
	} slot_update_t;

	logic [cmfb_pkg::ID_W-1:0]       bus0_base;
	logic [cmfb_pkg::ID_W-1:0]       bus1_base;
	logic [cmfb_pkg::SLOT_COUNT-1:0] turn_mask;
	logic [cmfb_pkg::ANGLE_W-1:0]    wrap_thr;

	logic [cmfb_pkg::ANGLE_W-1:0] angle_mem   [cmfb_pkg::SLOT_COUNT];
	logic [15:0]                  speed_mem   [cmfb_pkg::SLOT_COUNT];
	logic [15:0]                  current_mem [cmfb_pkg::SLOT_COUNT];
	logic [7:0]                   temp_mem    [cmfb_pkg::SLOT_COUNT];
	logic [cmfb_pkg::TURNS_W-1:0] turns_mem   [cmfb_pkg::SLOT_COUNT];

	slot_update_t slot_update_q [$];

	initial begin
		errors  = 0;
		checked = 0;
		pending = 0;
	end

	task automatic apply_feedback_frame(
		input logic                         bus,
		input logic [cmfb_pkg::ID_W-1:0]    id,
		input logic [cmfb_pkg::ANGLE_W-1:0] ang,
		input logic [15:0]                  spd,
		input logic [15:0]                  cur,
		input logic [7:0]                   tmp,
		input logic                         clr
	);
		logic [cmfb_pkg::ID_W-1:0]   base;
		logic [cmfb_pkg::ID_W-1:0]   offset;
		logic [cmfb_pkg::SLOT_W-1:0] slot;
		int                          step;
		int                          thr;
		slot_update_t                upd;
		base = bus ? bus1_base : bus0_base;
		if (clr) begin
			foreach (turns_mem[k])
				turns_mem[k] = '0;
		end
		if (id < base)
			return;
		offset = id - base;
		if (offset >= cmfb_pkg::SLOTS_PER_BUS)
			return;
		slot = bus ? offset[cmfb_pkg::SLOT_W-1:0]
			: cmfb_pkg::SLOT_W'(cmfb_pkg::BUS0_FIRST_SLOT + offset);
		step = int'(ang) - int'(angle_mem[slot]);
		thr  = int'(wrap_thr);
		angle_mem[slot]   = ang;
		speed_mem[slot]   = spd;
		current_mem[slot] = cur;
		temp_mem[slot]    = tmp;
		if (turn_mask[slot]) begin
			if (step > thr)
				turns_mem[slot] = turns_mem[slot] - 1;
			if (step < -thr)
				turns_mem[slot] = turns_mem[slot] + 1;
		end
		upd.slot        = slot;
		upd.angle       = angle_mem[slot];
		upd.speed       = speed_mem[slot];
		upd.current     = current_mem[slot];
		upd.temperature = temp_mem[slot];
		upd.turns       = turns_mem[slot];
		slot_update_q.push_back(upd);
	endtask

	task automatic check_field(input string name, input longint expv, input longint actv);
		if (expv != actv) begin
			$error("%s mismatch: expected %0d, got %0d", name, expv, actv);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		slot_update_t upd;
		if (!arst_n) begin
			bus0_base = cmfb_pkg::BUS0_BASE_RST;
			bus1_base = cmfb_pkg::BUS1_BASE_RST;
			turn_mask = cmfb_pkg::MASK_RST;
			wrap_thr  = cmfb_pkg::THRESH_RST;
			for (int k = 0; k < cmfb_pkg::SLOT_COUNT; k++) begin
				angle_mem[k]   = '0;
				speed_mem[k]   = '0;
				current_mem[k] = '0;
				temp_mem[k]    = '0;
				turns_mem[k]   = '0;
			end
			slot_update_q.delete();
		end else begin
			if (cfg_we) begin
				case (cmfb_pkg::cfg_reg_t'(cfg_addr))
					cmfb_pkg::REG_BUS0_BASE: bus0_base = cfg_wdata[cmfb_pkg::ID_W-1:0];
					cmfb_pkg::REG_BUS1_BASE: bus1_base = cfg_wdata[cmfb_pkg::ID_W-1:0];
					cmfb_pkg::REG_TURN_MASK: turn_mask = cfg_wdata[cmfb_pkg::SLOT_COUNT-1:0];
					cmfb_pkg::REG_WRAP_THR:  wrap_thr  = cfg_wdata[cmfb_pkg::ANGLE_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				apply_feedback_frame(s_tuser[0], s_tdata[10:0],
					{s_tdata[18:11], s_tdata[26:19]},
					{s_tdata[34:27], s_tdata[42:35]},
					{s_tdata[50:43], s_tdata[58:51]},
					s_tdata[66:59], s_tdata[67]);
			if (m_tvalid && m_tready) begin
				if (slot_update_q.size() == 0) begin
					$error("result for slot %0d with no frame waiting", m_tuser);
					errors++;
				end else begin
					upd = slot_update_q.pop_front();
					check_field("slot", longint'(upd.slot), longint'(m_tuser));
					check_field("angle", longint'(upd.angle), longint'(m_tdata[15:0]));
					check_field("speed", longint'(upd.speed),
						longint'($signed(m_tdata[31:16])));
					check_field("current", longint'(upd.current),
						longint'(m_tdata[47:32]));
					check_field("temperature", longint'(upd.temperature),
						longint'(m_tdata[55:48]));
					check_field("turns", longint'(upd.turns),
						longint'($signed(m_tdata[87:56])));
					checked++;
				end
			end
		end
		pending = slot_update_q.size();
	end

endmodule

>>> bench/tb_top.sv
module tb_top;

	localparam int STALL_LIMIT = 2000;
	localparam int LONG_HOLD   = 300;
	localparam int RAND_FRAMES = 106;
	localparam int PHASES      = 5;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	logic [71:0]                     s_tdata   = '0;
	logic [0:0]                      s_tuser   = '0;
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	logic [87:0]                     m_tdata;
	logic [cmfb_pkg::SLOT_W-1:0]     m_tuser;
	logic                            cfg_we    = 1'b0;
	logic [cmfb_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
	logic [cmfb_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

	int errors;
	int checked;
	int pending;
	int frames_sent   = 0;
	int settings_used = 0;
	int idle_cycles   = 0;
	bit tx_gaps       = 1'b1;
	bit rx_gaps       = 1'b1;
	bit long_hold_req = 1'b0;

	logic [cmfb_pkg::ID_W-1:0] cur_bus0 = cmfb_pkg::BUS0_BASE_RST;
	logic [cmfb_pkg::ID_W-1:0] cur_bus1 = cmfb_pkg::BUS1_BASE_RST;

	can_motor_feedback_turn_counter dut (.*);

	turn_count_checker feedback_check (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver: random back-pressure bursts, plus one long hold on request
	initial begin : sink
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold_req = 1'b0;
				m_tready <= 1'b1;
			end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_frame(
		input logic                         bus,
		input logic [cmfb_pkg::ID_W-1:0]    id,
		input logic [cmfb_pkg::ANGLE_W-1:0] ang,
		input logic [15:0]                  spd,
		input logic [15:0]                  cur,
		input logic [7:0]                   tmp,
		input logic                         clr
	);
		if (tx_gaps && $urandom_range(0, 4) == 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 12)) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= bus;
		s_tdata  <= {4'b0, clr, tmp, cur[7:0], cur[15:8], spd[7:0], spd[15:8],
			ang[7:0], ang[15:8], id};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		frames_sent++;
	endtask

	// drop valid and let the pipeline empty, including frames that give no result
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cmfb_pkg::cfg_reg_t r,
		input logic [cmfb_pkg::CFG_DATA_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= r;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_feedback_map(
		input logic [cmfb_pkg::ID_W-1:0]       b0,
		input logic [cmfb_pkg::ID_W-1:0]       b1,
		input logic [cmfb_pkg::SLOT_COUNT-1:0] mask,
		input logic [cmfb_pkg::ANGLE_W-1:0]    thr
	);
		wait_idle();
		write_reg(cmfb_pkg::REG_BUS0_BASE, cmfb_pkg::CFG_DATA_W'(b0));
		write_reg(cmfb_pkg::REG_BUS1_BASE, cmfb_pkg::CFG_DATA_W'(b1));
		write_reg(cmfb_pkg::REG_TURN_MASK, cmfb_pkg::CFG_DATA_W'(mask));
		write_reg(cmfb_pkg::REG_WRAP_THR, thr);
		cur_bus0 = b0;
		cur_bus1 = b1;
		settings_used++;
	endtask

	initial begin : stimulus
		logic [cmfb_pkg::ANGLE_W-1:0] ang;
		logic [cmfb_pkg::ID_W-1:0]    base;
		logic [cmfb_pkg::ID_W-1:0]    id;
		logic                         b;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset map: threshold edges, range ends, clear with and without a hit
		send_frame(1, 513, 9000, 16'h8000, 16'hFFFF, 8'hFF, 0);
		send_frame(1, 513, 100, 16'h7FFF, 16'h0000, 8'h00, 0);
		send_frame(1, 513, 5100, 16'hFFFF, 16'h5555, 8'hAA, 0);
		send_frame(1, 513, 100, 16'h0000, 16'hAAAA, 8'h55, 0);
		send_frame(1, 513, 5101, 16'h1234, 16'h8001, 8'h7F, 0);
		send_frame(1, 516, 16'hFFFF, 16'hAAAA, 16'h7FFE, 8'h80, 0);
		send_frame(1, 517, 16'h5555, 16'h5555, 16'h0001, 8'h01, 0);
		send_frame(1, 512, 16'hAAAA, 16'h0001, 16'h1111, 8'hFE, 0);
		send_frame(0, 513, 16'hFFFF, 16'hFFFE, 16'h2222, 8'h10, 0);
		send_frame(0, 516, 16'hFFFF, 16'h0100, 16'h3333, 8'h20, 0);
		send_frame(0, 2047, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1);
		send_frame(1, 513, 0, 16'h00FF, 16'hFF00, 8'h33, 0);
		send_frame(0, 514, 16'h8000, 16'hFF00, 16'h00FF, 8'hCC, 1);
		send_frame(0, 0, 16'h1234, 16'h4321, 16'h5678, 8'h99, 0);

		set_feedback_map(0, 2047, 8'hFF, 1);
		send_frame(0, 0, 2, 16'h0001, 16'h0002, 8'h03, 0);
		send_frame(0, 0, 4, 16'h8000, 16'hFFFF, 8'hFF, 0);
		send_frame(0, 0, 5, 16'h7FFF, 16'h0000, 8'h00, 0);
		send_frame(0, 3, 1, 16'h0000, 16'h8000, 8'h40, 0);
		send_frame(1, 2047, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 0);
		send_frame(0, 4, 16'h0F0F, 16'hF0F0, 16'h0F0F, 8'h0F, 0);

		set_feedback_map(2047, 0, 8'h00, 16'hFFFF);
		send_frame(0, 2047, 0, 16'h0F0F, 16'hF0F0, 8'hF0, 0);
		send_frame(1, 0, 16'hFFFF, 16'h1357, 16'h2468, 8'h5A, 0);
		send_frame(1, 3, 0, 16'hECA8, 16'hDB97, 8'hA5, 0);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: set_feedback_map(513, 513, 8'($urandom_range(0, 255)), 5000);
				1: set_feedback_map(cmfb_pkg::ID_W'($urandom_range(0, 2047)),
					cmfb_pkg::ID_W'($urandom_range(0, 2047)), 8'hFF,
					16'($urandom_range(1, 65535)));
				2: set_feedback_map(2044, 0, 8'($urandom_range(0, 255)), 1);
				3: set_feedback_map(cmfb_pkg::ID_W'($urandom_range(0, 2047)),
					cmfb_pkg::ID_W'($urandom_range(0, 2047)),
					8'($urandom_range(0, 255)), 16'($urandom_range(100, 3000)));
				default: set_feedback_map(cmfb_pkg::ID_W'($urandom_range(0, 2047)),
					cmfb_pkg::ID_W'($urandom_range(0, 2047)),
					8'($urandom_range(0, 255)), 16'($urandom_range(1000, 30000)));
			endcase
			tx_gaps = (p < PHASES - 1);
			rx_gaps = (p < PHASES - 1);
			if (p == 1)
				long_hold_req = 1'b1;
			for (int n = 0; n < RAND_FRAMES; n++) begin
				b    = 1'($urandom_range(0, 1));
				base = b ? cur_bus1 : cur_bus0;
				case ($urandom_range(0, 9))
					0: id = cmfb_pkg::ID_W'($urandom_range(0, 2047));
					1: id = base - cmfb_pkg::ID_W'(1);
					2: id = base + cmfb_pkg::ID_W'($urandom_range(4, 7));
					default: id = base + cmfb_pkg::ID_W'($urandom_range(0, 3));
				endcase
				// angles cluster near both ends and around mid-range so wraps happen often
				case ($urandom_range(0, 3))
					0: ang = cmfb_pkg::ANGLE_W'($urandom_range(0, 2000));
					1: ang = cmfb_pkg::ANGLE_W'($urandom_range(63535, 65535));
					2: ang = cmfb_pkg::ANGLE_W'($urandom_range(28000, 38000));
					default: ang = cmfb_pkg::ANGLE_W'($urandom_range(0, 65535));
				endcase
				send_frame(b, id, ang, 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
					$urandom_range(0, 29) == 0);
			end
		end
		wait_idle();

		$display("Sent %0d feedback frames over %0d ID/mask/threshold settings,", frames_sent,
			settings_used);
		$display("checked %0d slot updates under random stalls and one long output hold.",
			checked);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

>>> filelist.f
sv/cmfb_pkg.sv
sv/cmfb_slot_map.sv
sv/cmfb_turn_track.sv
sv/can_motor_feedback_turn_counter.sv
bench/turn_count_checker.sv
bench/tb_top.sv
